@@ sv/arc_pkg.sv @@
// shared widths, register indexes and reset values for the attack/release compressor
// no dependencies; the interfaces, the divider and the top level import this package
package arc_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned RATIO_W  = 8;
   localparam int unsigned LEVEL_W  = 15;
   localparam int unsigned COUNT_W  = 16;

   // excess / ratio divider and period divider sizes
   localparam int unsigned QDIV_NW = LEVEL_W;
   localparam int unsigned PDIV_NW = COUNT_W + 2;
   localparam int unsigned PDIV_DW = LEVEL_W + 1;

   localparam int unsigned CSR_AW = 3;
   localparam int unsigned CSR_DW = 16;

   localparam logic [CSR_AW-1:0] CSR_ENABLE    = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_RATIO     = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_THRESHOLD = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_ATTACK    = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_RELEASE   = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_MIDPOINT  = 3'd5;

   localparam logic               RST_ENABLE    = 1'b1;
   localparam logic [RATIO_W-1:0] RST_RATIO     = 8'd1;
   localparam logic [LEVEL_W-1:0] RST_THRESHOLD = 15'd512;
   localparam logic [COUNT_W-1:0] RST_ATTACK    = 16'd0;
   localparam logic [COUNT_W-1:0] RST_RELEASE   = 16'd0;
   localparam logic [LEVEL_W-1:0] RST_MIDPOINT  = 15'd512;

endpackage

@@ sv/arc_req_if.sv @@
// input sample channel: valid/ready handshake carrying one audio sample
// depends on arc_pkg
interface arc_req_if import arc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

@@ sv/arc_rsp_if.sv @@
// result sample channel: valid/ready handshake carrying one audio sample
// depends on arc_pkg
interface arc_rsp_if import arc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

@@ sv/arc_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// depends on arc_pkg for default widths; divisor must be nonzero
module arc_div import arc_pkg::*; #(
   parameter int unsigned NW = QDIV_NW,
   parameter int unsigned DW = RATIO_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int unsigned CNT_W = (NW > 1) ? $clog2(NW) : 1;

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    div_ff, div_in;

   logic [DW:0]      shifted;
   logic [DW:0]      trial;

   // dividend bits leave the top of quo_ff while quotient bits enter at the bottom
   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign trial   = shifted - {1'b0, div_ff};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      if (start) begin
         active_in = 1'b1;
         count_in  = CNT_W'(NW - 1);
         rem_in    = '0;
         quo_in    = dividend;
         div_in    = divisor;
      end else if (active_ff) begin
         if (!trial[DW]) begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         if (count_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/audio_attack_release_compressor.sv @@
// Attack/release audio compressor, one signed 16-bit sample in, one sample out.
// Depends on arc_pkg, arc_req_if, arc_rsp_if and arc_div.
//
// req_ch carries input samples, rsp_ch the results, both valid/ready; an item
// moves on a transfer, at a clock edge where valid and ready are both high.
// csr_we/csr_index/csr_wdata write the six control registers (enable, ratio,
// threshold, attack_samples, release_samples, midpoint); write only while idle.
//
// One sample is worked at a time. A sample that does not start an attack
// passes ST_EXEC and ST_PUT before rsp_ch.valid, and the next sample can
// transfer in the cycle after the result is loaded. A sample that starts an
// attack runs the excess through a 15-bit serial divider and, when the
// excess less its quotient is nonzero, through two 18-bit serial dividers in
// parallel for the attack and release periods.
// The result register parts the two channels: a new sample is taken while
// the last result still waits, but a stalled receiver holds the following
// result back and then blocks req_ch.
// Reset is synchronous: registers return to their defaults, all phase state
// clears, and no result is pending.
module audio_attack_release_compressor import arc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   arc_req_if.sink           req_ch,
   arc_rsp_if.source         rsp_ch,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVQ,
      ST_DIVP,
      ST_PUT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_ATTACK  = 2'd1,
      PH_RELEASE = 2'd2
   } phase_type;

   state_type           state_ff, state_in;
   logic [1:0]          phase_ff, phase_in;

   logic                enable_ff, enable_in;
   logic [RATIO_W-1:0]  ratio_ff, ratio_in;
   logic [LEVEL_W-1:0]  threshold_ff, threshold_in;
   logic [COUNT_W-1:0]  attack_samples_ff, attack_samples_in;
   logic [COUNT_W-1:0]  release_samples_ff, release_samples_in;
   logic [LEVEL_W-1:0]  midpoint_ff, midpoint_in;

   logic [COUNT_W-1:0]  gain_step_ff, gain_step_in;
   logic [COUNT_W-1:0]  phase_count_ff, phase_count_in;
   logic [COUNT_W-1:0]  attack_tick_ff, attack_tick_in;
   logic [COUNT_W-1:0]  release_tick_ff, release_tick_in;
   logic [COUNT_W-1:0]  attack_period_ff, attack_period_in;
   logic [COUNT_W-1:0]  release_period_ff, release_period_in;

   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [SAMPLE_W-1:0] res_ff, res_in;
   logic [LEVEL_W-1:0]  excess_ff, excess_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic [COUNT_W-1:0]  count_inc, atick_inc, rtick_inc;
   logic                atick_hit, rtick_hit;
   logic [COUNT_W-1:0]  gain_attack, gain_release, gain_use;
   logic                above_mid, above_thr;
   logic [SAMPLE_W-1:0] res_gain;
   logic [SAMPLE_W-1:0] excess_full;
   logic [LEVEL_W-1:0]  reduced;

   logic                qdiv_start, qdiv_done;
   logic [QDIV_NW-1:0]  qdiv_quo;
   logic [RATIO_W-1:0]  qdiv_divisor;
   logic                pdiv_start, pdiv_done, rdiv_done;
   logic [PDIV_NW-1:0]  adiv_quo, rdiv_quo;
   logic [PDIV_NW-1:0]  adiv_num, rdiv_num;
   logic [PDIV_DW-1:0]  pdiv_den;

   assign count_inc = phase_count_ff + 1'b1;
   assign atick_inc = attack_tick_ff + 1'b1;
   assign rtick_inc = release_tick_ff + 1'b1;
   assign atick_hit = (atick_inc == attack_period_ff);
   assign rtick_hit = (rtick_inc == release_period_ff);

   assign gain_attack  = atick_hit ? gain_step_ff + 1'b1 : gain_step_ff;
   assign gain_release = (rtick_hit && gain_step_ff != '0) ? gain_step_ff - 1'b1 : gain_step_ff;
   assign gain_use     = (phase_ff == PH_ATTACK) ? gain_attack : gain_release;

   assign above_mid = $signed(sample_ff) >= $signed({1'b0, midpoint_ff});
   assign above_thr = $signed(sample_ff) > $signed({1'b0, threshold_ff});
   assign res_gain  = above_mid ? sample_ff - gain_use : sample_ff + gain_use;

   // excess lies in 1..32767 whenever an attack starts
   assign excess_full  = sample_ff - {1'b0, threshold_ff};
   assign qdiv_divisor = (ratio_ff == '0) ? RATIO_W'(1) : ratio_ff;
   assign reduced      = excess_ff - qdiv_quo;

   // round to nearest: (2n + d) / (2d)
   assign adiv_num = {1'b0, attack_samples_ff, 1'b0} + PDIV_NW'(reduced);
   assign rdiv_num = {1'b0, release_samples_ff, 1'b0} + PDIV_NW'(reduced);
   assign pdiv_den = {reduced, 1'b0};

   arc_div #(.NW(QDIV_NW), .DW(RATIO_W)) u_qdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (qdiv_start),
      .dividend (excess_ff),
      .divisor  (qdiv_divisor),
      .done     (qdiv_done),
      .quotient (qdiv_quo)
   );

   arc_div #(.NW(PDIV_NW), .DW(PDIV_DW)) u_adiv (
      .clock    (clock),
      .reset    (reset),
      .start    (pdiv_start),
      .dividend (adiv_num),
      .divisor  (pdiv_den),
      .done     (pdiv_done),
      .quotient (adiv_quo)
   );

   arc_div #(.NW(PDIV_NW), .DW(PDIV_DW)) u_rdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (pdiv_start),
      .dividend (rdiv_num),
      .divisor  (pdiv_den),
      .done     (rdiv_done),
      .quotient (rdiv_quo)
   );

   always_comb begin
      state_in           = state_ff;
      phase_in           = phase_ff;
      enable_in          = enable_ff;
      ratio_in           = ratio_ff;
      threshold_in       = threshold_ff;
      attack_samples_in  = attack_samples_ff;
      release_samples_in = release_samples_ff;
      midpoint_in        = midpoint_ff;
      gain_step_in       = gain_step_ff;
      phase_count_in     = phase_count_ff;
      attack_tick_in     = attack_tick_ff;
      release_tick_in    = release_tick_ff;
      attack_period_in   = attack_period_ff;
      release_period_in  = release_period_ff;
      sample_in          = sample_ff;
      res_in             = res_ff;
      excess_in          = excess_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_data_in        = rsp_data_ff;
      pdiv_start         = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_in          = csr_wdata[0];
            CSR_RATIO:     ratio_in           = csr_wdata[RATIO_W-1:0];
            CSR_THRESHOLD: threshold_in       = csr_wdata[LEVEL_W-1:0];
            CSR_ATTACK:    attack_samples_in  = csr_wdata[COUNT_W-1:0];
            CSR_RELEASE:   release_samples_in = csr_wdata[COUNT_W-1:0];
            CSR_MIDPOINT:  midpoint_in        = csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               sample_in = req_ch.sample_in;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in   = sample_ff;
            state_in = ST_PUT;
            if (enable_ff) begin
               unique case (phase_ff)
                  PH_ATTACK: begin
                     phase_count_in = count_inc;
                     gain_step_in   = gain_attack;
                     attack_tick_in = atick_hit ? '0 : atick_inc;
                     res_in         = res_gain;
                     if (count_inc == attack_samples_ff) begin
                        phase_count_in = '0;
                        attack_tick_in = '0;
                        phase_in       = PH_RELEASE;
                     end
                  end
                  PH_RELEASE: begin
                     phase_count_in  = count_inc;
                     gain_step_in    = gain_release;
                     release_tick_in = rtick_hit ? '0 : rtick_inc;
                     res_in          = res_gain;
                     if (count_inc == release_samples_ff) begin
                        phase_count_in  = '0;
                        release_tick_in = '0;
                        gain_step_in    = '0;
                        phase_in        = PH_IDLE;
                     end
                  end
                  default: begin
                     // idle, and the unused phase code, may start an attack
                     if (above_thr) begin
                        phase_in  = PH_ATTACK;
                        excess_in = excess_full[LEVEL_W-1:0];
                        state_in  = ST_DIVQ;
                     end
                  end
               endcase
            end
         end
         ST_DIVQ: begin
            // divider start comes from qdiv_kick_ff, registered along with the excess
            if (qdiv_done) begin
               if (reduced != '0) begin
                  pdiv_start = 1'b1;
                  state_in   = ST_DIVP;
               end else begin
                  state_in = ST_PUT;
               end
            end
         end
         ST_DIVP: begin
            if (pdiv_done && rdiv_done) begin
               attack_period_in  = adiv_quo[COUNT_W-1:0];
               release_period_in = rdiv_quo[COUNT_W-1:0];
               state_in          = ST_PUT;
            end
         end
         ST_PUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // quotient divider kicked off from the cycle after the trigger
   logic qdiv_kick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         phase_ff           <= PH_IDLE;
         enable_ff          <= RST_ENABLE;
         ratio_ff           <= RST_RATIO;
         threshold_ff       <= RST_THRESHOLD;
         attack_samples_ff  <= RST_ATTACK;
         release_samples_ff <= RST_RELEASE;
         midpoint_ff        <= RST_MIDPOINT;
         gain_step_ff       <= '0;
         phase_count_ff     <= '0;
         attack_tick_ff     <= '0;
         release_tick_ff    <= '0;
         attack_period_ff   <= '0;
         release_period_ff  <= '0;
         rsp_valid_ff       <= 1'b0;
         qdiv_kick_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         phase_ff           <= phase_in;
         enable_ff          <= enable_in;
         ratio_ff           <= ratio_in;
         threshold_ff       <= threshold_in;
         attack_samples_ff  <= attack_samples_in;
         release_samples_ff <= release_samples_in;
         midpoint_ff        <= midpoint_in;
         gain_step_ff       <= gain_step_in;
         phase_count_ff     <= phase_count_in;
         attack_tick_ff     <= attack_tick_in;
         release_tick_ff    <= release_tick_in;
         attack_period_ff   <= attack_period_in;
         release_period_ff  <= release_period_in;
         rsp_valid_ff       <= rsp_valid_in;
         qdiv_kick_ff       <= (state_ff == ST_EXEC) && (state_in == ST_DIVQ);
      end
      sample_ff   <= sample_in;
      res_ff      <= res_in;
      excess_ff   <= excess_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign qdiv_start = qdiv_kick_ff;

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = rsp_data_ff;

endmodule

@@ sv/arc_checker.sv @@
// port-level checks on the compressor's handshakes over time
// depends on the top level audio_attack_release_compressor, attached by bind
module arc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a result waiting on a stalled receiver stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while receiver stalled");

   // reset leaves nothing pending on the result side
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // after a transfer, req_ready stays low while the sample passes the exec and put states
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("input taken again too soon");

endmodule

bind audio_attack_release_compressor arc_checker u_arc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);
